>>> hdl/utfd_pkg.sv
package utfd_pkg;

  // Byte class masks and patterns
  localparam logic [7:0] LeadMask1  = 8'h80;
  localparam logic [7:0] LeadMask2  = 8'hE0;
  localparam logic [7:0] LeadPat2   = 8'hC0;
  localparam logic [7:0] LeadMask3  = 8'hF0;
  localparam logic [7:0] LeadPat3   = 8'hE0;
  localparam logic [7:0] LeadMask4  = 8'hF8;
  localparam logic [7:0] LeadPat4   = 8'hF0;
  localparam logic [7:0] ContMask   = 8'hC0;
  localparam logic [7:0] ContPat    = 8'h80;
  localparam logic [7:0] Pay2Mask   = 8'h1F;
  localparam logic [7:0] Pay3Mask   = 8'h0F;
  localparam logic [7:0] Pay4Mask   = 8'h07;
  localparam logic [7:0] ContPay    = 8'h3F;

  localparam int CpW  = 21;
  localparam int LenW = 3;
  localparam int RemW = 2;

  // Sequence lengths
  localparam logic [LenW-1:0] Len0 = 3'd0;
  localparam logic [LenW-1:0] Len1 = 3'd1;
  localparam logic [LenW-1:0] Len2 = 3'd2;
  localparam logic [LenW-1:0] Len3 = 3'd3;
  localparam logic [LenW-1:0] Len4 = 3'd4;

  // Smallest legal two-byte payload
  localparam logic [4:0] MinPay2 = 5'd2;

  // Queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // One queue entry: an optional error beat, then the main beat
  typedef struct packed {
    logic            pre_err;
    logic [CpW-1:0]  cp;
    logic [LenW-1:0] len;
    logic            err;
  } res_entry_t;

endpackage

>>> hdl/utfd_front.sv
module utfd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                q_full,
  output logic                q_push,
  output utfd_pkg::res_entry_t q_entry
);

  logic [utfd_pkg::CpW-1:0]  partial_r, partial_nxt;
  logic [utfd_pkg::RemW-1:0] rem_r, rem_nxt;
  logic [utfd_pkg::LenW-1:0] total_r, total_nxt;

  // lead byte decode
  logic                      lead_has;
  logic [utfd_pkg::CpW-1:0]  lead_cp;
  logic [utfd_pkg::LenW-1:0] lead_len;
  logic                      lead_err;
  logic [utfd_pkg::CpW-1:0]  lead_part;
  logic [utfd_pkg::RemW-1:0] lead_rem;
  logic [utfd_pkg::LenW-1:0] lead_tot;
  logic                      accept;
  logic                      is_cont;
  logic [utfd_pkg::CpW-1:0]  shifted;
  logic                      produce;
  utfd_pkg::res_entry_t      entry;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_cont  = (in_byte & utfd_pkg::ContMask) == utfd_pkg::ContPat;
  assign shifted  = {partial_r[utfd_pkg::CpW-7:0], 6'(in_byte & utfd_pkg::ContPay)};

  always_comb begin
    lead_has  = 1'b1;
    lead_cp   = '0;
    lead_len  = utfd_pkg::Len0;
    lead_err  = 1'b1;
    lead_part = '0;
    lead_rem  = '0;
    lead_tot  = utfd_pkg::Len0;
    if ((in_byte & utfd_pkg::LeadMask1) == 8'h00) begin
      lead_cp  = utfd_pkg::CpW'(in_byte);
      lead_len = utfd_pkg::Len1;
      lead_err = 1'b0;
    end else if ((in_byte & utfd_pkg::LeadMask2) == utfd_pkg::LeadPat2) begin
      if (in_byte[4:0] >= utfd_pkg::MinPay2) begin
        lead_has  = 1'b0;
        lead_part = utfd_pkg::CpW'(in_byte & utfd_pkg::Pay2Mask);
        lead_rem  = 2'd1;
        lead_tot  = utfd_pkg::Len2;
      end
    end else if ((in_byte & utfd_pkg::LeadMask3) == utfd_pkg::LeadPat3) begin
      lead_has  = 1'b0;
      lead_part = utfd_pkg::CpW'(in_byte & utfd_pkg::Pay3Mask);
      lead_rem  = 2'd2;
      lead_tot  = utfd_pkg::Len3;
    end else if ((in_byte & utfd_pkg::LeadMask4) == utfd_pkg::LeadPat4) begin
      lead_has  = 1'b0;
      lead_part = utfd_pkg::CpW'(in_byte & utfd_pkg::Pay4Mask);
      lead_rem  = 2'd3;
      lead_tot  = utfd_pkg::Len4;
    end
  end

  // sequence state and result entry
  always_comb begin
    partial_nxt   = partial_r;
    rem_nxt       = rem_r;
    total_nxt     = total_r;
    produce       = 1'b0;
    entry.pre_err = 1'b0;
    entry.cp      = lead_cp;
    entry.len     = lead_len;
    entry.err     = lead_err;
    if (rem_r == '0) begin
      produce     = lead_has;
      partial_nxt = lead_part;
      rem_nxt     = lead_rem;
      total_nxt   = lead_tot;
    end else if (is_cont) begin
      rem_nxt = rem_r - 2'd1;
      if (rem_r == 2'd1) begin
        produce     = 1'b1;
        entry.cp    = shifted;
        entry.len   = total_r;
        entry.err   = 1'b0;
        partial_nxt = '0;
        total_nxt   = utfd_pkg::Len0;
      end else begin
        partial_nxt = shifted;
      end
    end else begin
      // broken sequence: error, then the byte restarts as a lead
      produce     = 1'b1;
      partial_nxt = lead_part;
      rem_nxt     = lead_rem;
      total_nxt   = lead_tot;
      if (lead_has) begin
        entry.pre_err = 1'b1;
      end else begin
        entry.cp  = '0;
        entry.len = utfd_pkg::Len0;
        entry.err = 1'b1;
      end
    end
  end

  assign q_push  = accept && produce;
  assign q_entry = entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      rem_r     <= '0;
      total_r   <= '0;
    end else if (accept) begin
      partial_r <= partial_nxt;
      rem_r     <= rem_nxt;
      total_r   <= total_nxt;
    end
  end

endmodule

>>> hdl/utfd_queue.sv
module utfd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  utfd_pkg::res_entry_t push_entry,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output utfd_pkg::res_entry_t head
);

  utfd_pkg::res_entry_t mem [utfd_pkg::QDepth];
  logic [utfd_pkg::QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [utfd_pkg::QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [utfd_pkg::QCntW-1:0] cnt_r, cnt_nxt;
  logic                       do_pop;

  assign full      = cnt_r == utfd_pkg::QCntW'(utfd_pkg::QDepth);
  assign not_empty = cnt_r != '0;
  assign head      = mem[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

endmodule

>>> hdl/utfd_back.sv
module utfd_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_not_empty,
  input  utfd_pkg::res_entry_t     q_head,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [utfd_pkg::CpW-1:0] out_code_point,
  output logic [utfd_pkg::LenW-1:0] out_seq_length,
  output logic                     out_is_error,
  output logic                     out_is_last
);

  logic                 busy_r, busy_nxt;
  logic                 pre_r, pre_nxt;
  utfd_pkg::res_entry_t ent_r;
  logic                 beat_done;

  assign beat_done = busy_r && out_ready;
  assign q_pop     = q_not_empty && (!busy_r || (out_ready && !pre_r));

  // beat sequencing: optional error beat, then the main beat
  always_comb begin
    busy_nxt = busy_r;
    pre_nxt  = pre_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      pre_nxt  = q_head.pre_err;
    end else if (beat_done) begin
      if (pre_r) begin
        pre_nxt = 1'b0;
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pre_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      pre_r  <= pre_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r <= q_head;
    end
  end

  assign out_valid      = busy_r;
  assign out_code_point = pre_r ? '0 : ent_r.cp;
  assign out_seq_length = pre_r ? utfd_pkg::Len0 : ent_r.len;
  assign out_is_error   = pre_r ? 1'b1 : ent_r.err;
  assign out_is_last    = !pre_r;

endmodule

>>> hdl/utf8_stream_decoder.sv
// UTF-8 stream decoder.
// Input channel (in_valid/in_ready/in_byte) takes one byte per beat. Result
// channel (out_valid/out_ready/out_*) gives one result per beat: a code point
// with its sequence length, or an error flag with code point and length zero.
// A byte can cause zero, one or two results; out_is_last marks the final
// result of a byte. A broken sequence gives an error beat, and the same byte is
// then handled as a new lead.
// A result is written into the queue when the byte that completes it is accepted,
// then moves into the back-end output register, from which it leaves.
// Throughput: one byte per cycle while the queue is not full; a byte with two
// results holds the back end for both of its beats. The front decodes each byte
// combinationally; the back end drains one beat per cycle while out_ready is high.
// A 4-entry queue sits between decode and output; when the receiver stalls,
// the queue fills and in_ready drops only once it is full.
// Reset (rst_n, synchronous, active low) empties the queue and output and
// returns the decoder to waiting for a lead byte. A sequence cut off by reset before
// its last byte gives no result.
module utf8_stream_decoder (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [utfd_pkg::CpW-1:0]  out_code_point,
  output logic [utfd_pkg::LenW-1:0] out_seq_length,
  output logic                      out_is_error,
  output logic                      out_is_last
);

  logic                 q_full;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_not_empty;
  utfd_pkg::res_entry_t q_entry;
  utfd_pkg::res_entry_t q_head;

  utfd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  utfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  utfd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_not_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_point (out_code_point),
    .out_seq_length (out_seq_length),
    .out_is_error   (out_is_error),
    .out_is_last    (out_is_last)
  );

endmodule

>>> test/tb_utf8_stream_decoder.sv
module tb_utf8_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 300000;
  localparam int DrainMark  = -1;   // feed entry: hold off until all results are in
  localparam int TailCycles = 20;

  typedef struct {
    logic [utfd_pkg::CpW-1:0]  cp;
    logic [utfd_pkg::LenW-1:0] len;
    logic                      err;
    logic                      last;
  } cp_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [7:0]                in_byte;
  logic                      out_valid;
  logic                      out_ready;
  logic [utfd_pkg::CpW-1:0]  out_code_point;
  logic [utfd_pkg::LenW-1:0] out_seq_length;
  logic                      out_is_error;
  logic                      out_is_last;

  int                        byte_feed[$];
  cp_result_t                results_due[$];
  logic                      in_fire = 1'b0;
  int                        snd_idle_pct;
  int                        rcv_idle_pct;
  int                        err_cnt = 0;
  int                        cycle_cnt = 0;

  // decoder state mirror
  logic [utfd_pkg::CpW-1:0]  seq_value;
  logic [utfd_pkg::RemW-1:0] seq_left;
  logic [utfd_pkg::LenW-1:0] seq_len;

  utf8_stream_decoder DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_point (out_code_point),
    .out_seq_length (out_seq_length),
    .out_is_error   (out_is_error),
    .out_is_last    (out_is_last)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  task automatic push_result(input logic [utfd_pkg::CpW-1:0] cp,
                             input logic [utfd_pkg::LenW-1:0] len,
                             input logic err);
    cp_result_t r;
    r.cp   = cp;
    r.len  = len;
    r.err  = err;
    r.last = 1'b0;
    results_due.insert(results_due.size(), r);
  endtask

  // Byte seen while idle: single byte, error, or start of a sequence
  task automatic take_lead(input logic [7:0] b, inout int n);
    if ((b & utfd_pkg::LeadMask1) == 8'h00) begin
      push_result(utfd_pkg::CpW'(b), utfd_pkg::Len1, 1'b0);
      n++;
    end else if ((b & utfd_pkg::LeadMask2) == utfd_pkg::LeadPat2) begin
      if ((b & utfd_pkg::Pay2Mask) < utfd_pkg::MinPay2) begin
        push_result('0, utfd_pkg::Len0, 1'b1);
        n++;
      end else begin
        seq_value = utfd_pkg::CpW'(b & utfd_pkg::Pay2Mask);
        seq_left  = utfd_pkg::RemW'(1);
        seq_len   = utfd_pkg::Len2;
      end
    end else if ((b & utfd_pkg::LeadMask3) == utfd_pkg::LeadPat3) begin
      seq_value = utfd_pkg::CpW'(b & utfd_pkg::Pay3Mask);
      seq_left  = utfd_pkg::RemW'(2);
      seq_len   = utfd_pkg::Len3;
    end else if ((b & utfd_pkg::LeadMask4) == utfd_pkg::LeadPat4) begin
      seq_value = utfd_pkg::CpW'(b & utfd_pkg::Pay4Mask);
      seq_left  = utfd_pkg::RemW'(3);
      seq_len   = utfd_pkg::Len4;
    end else begin
      push_result('0, utfd_pkg::Len0, 1'b1);
      n++;
    end
  endtask

  // Expected results for one accepted byte
  task automatic decode_byte(input logic [7:0] b);
    int         n;
    cp_result_t r;
    n = 0;
    if (seq_left == '0) begin
      take_lead(b, n);
    end else if ((b & utfd_pkg::ContMask) == utfd_pkg::ContPat) begin
      seq_value = (seq_value << 6) | utfd_pkg::CpW'(b & utfd_pkg::ContPay);
      seq_left  = seq_left - 1'b1;
      if (seq_left == '0) begin
        push_result(seq_value, seq_len, 1'b0);
        n = 1;
        seq_value = '0;
        seq_len   = utfd_pkg::Len0;
      end
    end else begin
      // broken sequence: error, then the byte as a fresh lead
      seq_value = '0;
      seq_left  = '0;
      seq_len   = utfd_pkg::Len0;
      push_result('0, utfd_pkg::Len0, 1'b1);
      n = 1;
      take_lead(b, n);
    end
    if (n > 0) begin
      r = results_due.pop_back();
      r.last = 1'b1;
      results_due.insert(results_due.size(), r);
    end
  endtask

  // Mostly well-formed sequences, some noise and truncated sequences
  task automatic add_stream(input int count);
    int         pushed;
    int         kind;
    int         conts;
    logic [7:0] lead;
    pushed = 0;
    while (pushed < count) begin
      kind = $urandom_range(99);
      if (kind < 10) begin
        byte_feed.insert(byte_feed.size(), $urandom_range(255));
        pushed++;
      end else begin
        case ($urandom_range(3))
          0: begin
            lead  = 8'($urandom_range(127));
            conts = 0;
          end
          1: begin
            lead  = utfd_pkg::LeadPat2 | 8'($urandom_range(31));
            conts = 1;
          end
          2: begin
            lead  = utfd_pkg::LeadPat3 | 8'($urandom_range(15));
            conts = 2;
          end
          default: begin
            lead  = utfd_pkg::LeadPat4 | 8'($urandom_range(7));
            conts = 3;
          end
        endcase
        if (kind < 20 && conts > 0) conts = $urandom_range(conts - 1);
        byte_feed.insert(byte_feed.size(), int'(lead));
        pushed++;
        repeat (conts) begin
          byte_feed.insert(byte_feed.size(),
                           int'(utfd_pkg::ContPat | 8'($urandom_range(63))));
          pushed++;
        end
      end
    end
  endtask

  task automatic wait_feed_empty();
    while (byte_feed.size() != 0 || in_valid) @(posedge clk);
  endtask

  // Driver and receiver ready, both on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (byte_feed.size() != 0 && byte_feed[0] == DrainMark) begin
        if (results_due.size() == 0) byte_feed.delete(0);
        in_valid <= 1'b0;
      end else if (byte_feed.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        in_valid <= 1'b1;
        in_byte  <= 8'(byte_feed.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Monitor: predict on each input beat, then check each result beat
  always @(posedge clk) begin
    cp_result_t want;
    cycle_cnt <= cycle_cnt + 1;
    in_fire   <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) decode_byte(in_byte);
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result cp=%h len=%0d err=%b last=%b",
                                    out_code_point, out_seq_length, out_is_error,
                                    out_is_last));
        end else begin
          want = results_due.pop_front();
          if (out_code_point !== want.cp)
            report_mismatch($sformatf("code_point %h, want %h", out_code_point, want.cp));
          if (out_seq_length !== want.len)
            report_mismatch($sformatf("seq_length %0d, want %0d", out_seq_length, want.len));
          if (out_is_error !== want.err)
            report_mismatch($sformatf("is_error %b, want %b", out_is_error, want.err));
          if (out_is_last !== want.last)
            report_mismatch($sformatf("is_last %b, want %b", out_is_last, want.last));
        end
      end
    end
  end

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [7:0] directed[] = '{
      8'h00, 8'h7F, 8'h80, 8'hC1, 8'hFF,       // extremes, bad leads, low two-byte lead
      8'hC2, 8'h80,                            // smallest two-byte form
      8'hEF, 8'hBF, 8'hBF,                     // three-byte
      8'hF7, 8'hBF, 8'hBF, 8'hBF,              // largest four-byte payload
      8'hE1, 8'h41,                            // broken, then a single byte
      8'hF0, 8'h80, 8'hC3, 8'hA9,              // broken, then a new sequence
      8'hC2, 8'hC0,                            // broken, then a bad lead
      8'hE2, 8'hF8                             // broken, then an invalid lead
    };
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_byte      = 8'h00;
    out_ready    = 1'b0;
    snd_idle_pct = 13;
    rcv_idle_pct = 57;
    seq_value    = '0;
    seq_left     = '0;
    seq_len      = utfd_pkg::Len0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) byte_feed.insert(byte_feed.size(), int'(directed[i]));
    add_stream(330);
    byte_feed.insert(byte_feed.size(), DrainMark);
    add_stream(330);
    wait_feed_empty();

    snd_idle_pct = 57;
    rcv_idle_pct = 13;
    add_stream(330);
    byte_feed.insert(byte_feed.size(), DrainMark);
    add_stream(330);
    wait_feed_empty();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    add_stream(330);
    byte_feed.insert(byte_feed.size(), DrainMark);
    add_stream(330);
    wait_feed_empty();

    while (results_due.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> utf8_stream_decoder.f
hdl/utfd_pkg.sv
hdl/utfd_front.sv
hdl/utfd_queue.sv
hdl/utfd_back.sv
hdl/utf8_stream_decoder.sv
test/tb_utf8_stream_decoder.sv
